@@ src/integer_to_ascii_radix_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the integer to ASCII converter
// Implication checks sampled on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_RADIX_TOP_ASSERT_SVH
`define INTEGER_TO_ASCII_RADIX_TOP_ASSERT_SVH

// same-cycle implication
`define I2A_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("i2a: same-cycle check failed");

// next-cycle implication
`define I2A_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("i2a: next-cycle check failed");

`endif

@@ src/i2a_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2a_pkg
// Types, character codes and helpers shared by the converter modules.
// ----------------------------------------------------------------------------
package i2a_pkg;

  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned DEC_W      = 32;
  localparam int unsigned BCD_DIGITS = 10;
  localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
  localparam int unsigned NDIG_W     = 5;
  localparam int unsigned CNT_W      = 6;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_UP_A  = 8'h41;

  localparam logic [NDIG_W-1:0] NDIG_DEC = NDIG_W'(BCD_DIGITS);
  localparam logic [NDIG_W-1:0] NDIG_H32 = NDIG_W'(8);
  localparam logic [NDIG_W-1:0] NDIG_H64 = NDIG_W'(16);

  typedef enum logic [2:0] {
    OP_SDEC = 3'd0,
    OP_UDEC = 3'd1,
    OP_HEXL = 3'd2,
    OP_HEXU = 3'd3,
    OP_PTR  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_e;

  // Emitter load: digits left-justified, MS nibble first, optional prefix.
  typedef struct packed {
    logic                  load;
    logic [VALUE_W-1:0]    digits;
    logic [NDIG_W-1:0]     ndig;
    logic [1:0]            pfx_n;
    logic [15:0]           pfx;
    logic                  upper;
  } load_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CH_UP_A : CH_LOW_A;
    if (d < 4'd10) begin
      digit_char = CH_ZERO + {4'h0, d};
    end else begin
      digit_char = base + {4'h0, d} - 8'd10;
    end
  endfunction

endpackage

@@ src/integer_to_ascii_radix_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_top
// Prints one number per item as ASCII characters, most significant first.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata                                  tlast
// s_axis   in   [2:0] op, [66:3] value, [71:67] zero   -
// m_axis   out  [7:0] char_code                        last
//
// Decimal kinds: 32 serial BCD shifts and a load after the accept, then one
// step per digit position (10) plus one for a minus sign; hex takes 8 digit
// positions and pointer 16 plus a two-character prefix. Leading zero positions
// take a step each but emit nothing.
// Reset is asynchronous, active low, and clears all control state.
// A stalled output holds the emitter; once the last character enters the output
// register, the emitter goes idle and the state returns to ST_IDLE to take the next item.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // [2:0] op, [66:3] value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] char_code
  output logic        m_axis_tlast    // last
);

  i2a_pkg::state_e state_q, state_d;
  i2a_pkg::load_t  ld;

  logic [2:0]                  op;
  logic [i2a_pkg::VALUE_W-1:0] value;
  logic [i2a_pkg::DEC_W-1:0]   low, mag;
  logic                        accept, is_dec, is_hex, neg;
  logic                        neg_q, neg_d;
  logic                        conv_start, conv_done, emit_busy;
  logic [i2a_pkg::BCD_W-1:0]   bcd;

  assign op     = s_axis_tdata[2:0];
  assign value  = s_axis_tdata[66:3];
  assign low    = value[i2a_pkg::DEC_W-1:0];
  assign accept = s_axis_tvalid && s_axis_tready;
  assign is_dec = (op == i2a_pkg::OP_SDEC) || (op == i2a_pkg::OP_UDEC);
  assign is_hex = (op == i2a_pkg::OP_HEXL) || (op == i2a_pkg::OP_HEXU)
                  || (op == i2a_pkg::OP_PTR);
  assign neg    = (op == i2a_pkg::OP_SDEC) && low[i2a_pkg::DEC_W-1];
  assign mag    = neg ? (~low + 1'b1) : low;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      i2a_pkg::ST_IDLE: begin
        if (accept && is_dec) begin
          state_d = i2a_pkg::ST_CONV;
        end else if (accept && is_hex) begin
          state_d = i2a_pkg::ST_EMIT;
        end
      end
      i2a_pkg::ST_CONV: begin
        if (conv_done) begin
          state_d = i2a_pkg::ST_EMIT;
        end
      end
      i2a_pkg::ST_EMIT: begin
        if (!emit_busy) begin
          state_d = i2a_pkg::ST_IDLE;
        end
      end
      default: state_d = i2a_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = 1'b0;
    conv_start    = 1'b0;
    neg_d         = neg_q;
    ld            = '0;
    case (state_q)
      i2a_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (accept && is_dec) begin
          conv_start = 1'b1;
          neg_d      = neg;
        end else if (accept && is_hex) begin
          ld.load = 1'b1;
          if (op == i2a_pkg::OP_PTR) begin
            ld.digits = value;
            ld.ndig   = i2a_pkg::NDIG_H64;
            ld.pfx_n  = 2'd2;
            ld.pfx    = {i2a_pkg::CH_ZERO, i2a_pkg::CH_X};
          end else begin
            ld.digits = {low, {i2a_pkg::VALUE_W-i2a_pkg::DEC_W{1'b0}}};
            ld.ndig   = i2a_pkg::NDIG_H32;
            ld.upper  = (op == i2a_pkg::OP_HEXU);
          end
        end
      end
      i2a_pkg::ST_CONV: begin
        if (conv_done) begin
          ld.load   = 1'b1;
          ld.digits = {bcd, {i2a_pkg::VALUE_W-i2a_pkg::BCD_W{1'b0}}};
          ld.ndig   = i2a_pkg::NDIG_DEC;
          ld.pfx_n  = neg_q ? 2'd1 : 2'd0;
          ld.pfx    = {i2a_pkg::CH_MINUS, 8'h00};
        end
      end
      i2a_pkg::ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= i2a_pkg::ST_IDLE;
      neg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      neg_q   <= neg_d;
    end
  end

  i2a_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_start),
    .bin_i   (mag),
    .done_o  (conv_done),
    .bcd_o   (bcd)
  );

  i2a_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (ld),
    .busy_o        (emit_busy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

`include "integer_to_ascii_radix_top_assert.svh"

  `I2A_ASSERT_IMP(a_ready_emit_idle, s_axis_tready, !emit_busy)
  `I2A_ASSERT_IMP(a_done_in_conv, conv_done, state_q == i2a_pkg::ST_CONV)
  `I2A_ASSERT_NXT(a_emit_to_idle, (state_q == i2a_pkg::ST_EMIT) && !emit_busy,
                  state_q == i2a_pkg::ST_IDLE)

endmodule

@@ src/i2a_dabble.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2a_dabble
// Bit-serial binary to BCD converter (shift and add three), one bit a cycle.
// ----------------------------------------------------------------------------
module i2a_dabble (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [i2a_pkg::DEC_W-1:0]   bin_i,
  output logic                        done_o,
  output logic [i2a_pkg::BCD_W-1:0]   bcd_o
);

  logic [i2a_pkg::DEC_W-1:0] bin_q, bin_d;
  logic [i2a_pkg::BCD_W-1:0] bcd_q, bcd_d, adj;
  logic [i2a_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                      done_q, done_d;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < int'(i2a_pkg::BCD_DIGITS); i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d = bin_i;
      bcd_d = '0;
      cnt_d = i2a_pkg::CNT_W'(i2a_pkg::DEC_W);
    end else if (cnt_q != '0) begin
      bcd_d  = {adj[i2a_pkg::BCD_W-2:0], bin_q[i2a_pkg::DEC_W-1]};
      bin_d  = {bin_q[i2a_pkg::DEC_W-2:0], 1'b0};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == i2a_pkg::CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

@@ src/i2a_emit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2a_emit
// Nibble shift register: drops leading zeros, maps digits to ASCII and
// drives the registered output item stream.
// ----------------------------------------------------------------------------
module i2a_emit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  i2a_pkg::load_t  load_i,
  output logic            busy_o,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] char_code
  output logic            m_axis_tlast    // last
);

  logic [i2a_pkg::VALUE_W-1:0] sr_q, sr_d;
  logic [i2a_pkg::NDIG_W-1:0]  rem_q, rem_d;
  logic [1:0]                  pfx_n_q, pfx_n_d;
  logic [15:0]                 pfx_q, pfx_d;
  logic                        upper_q, upper_d;
  logic                        started_q, started_d;
  logic                        ov_q, ov_d;
  logic [7:0]                  och_q, och_d;
  logic                        olast_q, olast_d;

  logic       busy, step, skip;
  logic [3:0] dig;

  assign busy = (pfx_n_q != '0) || (rem_q != '0);
  assign step = busy && (!ov_q || m_axis_tready);
  assign dig  = sr_q[i2a_pkg::VALUE_W-1 -: 4];
  assign skip = (pfx_n_q == '0) && !started_q && (dig == 4'h0)
                && (rem_q != i2a_pkg::NDIG_W'(1));

  always_comb begin
    sr_d      = sr_q;
    rem_d     = rem_q;
    pfx_n_d   = pfx_n_q;
    pfx_d     = pfx_q;
    upper_d   = upper_q;
    started_d = started_q;
    ov_d      = ov_q && !m_axis_tready;
    och_d     = och_q;
    olast_d   = olast_q;
    if (load_i.load) begin
      sr_d      = load_i.digits;
      rem_d     = load_i.ndig;
      pfx_n_d   = load_i.pfx_n;
      pfx_d     = load_i.pfx;
      upper_d   = load_i.upper;
      started_d = 1'b0;
    end else if (step) begin
      if (pfx_n_q != '0) begin
        ov_d    = 1'b1;
        och_d   = pfx_q[15:8];
        olast_d = 1'b0;
        pfx_d   = {pfx_q[7:0], 8'h00};
        pfx_n_d = pfx_n_q - 1'b1;
      end else begin
        sr_d  = {sr_q[i2a_pkg::VALUE_W-5:0], 4'h0};
        rem_d = rem_q - 1'b1;
        if (!skip) begin
          ov_d      = 1'b1;
          och_d     = i2a_pkg::digit_char(dig, upper_q);
          olast_d   = (rem_q == i2a_pkg::NDIG_W'(1));
          started_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q     <= '0;
      pfx_n_q   <= '0;
      started_q <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      rem_q     <= rem_d;
      pfx_n_q   <= pfx_n_d;
      started_q <= started_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q    <= sr_d;
    pfx_q   <= pfx_d;
    upper_q <= upper_d;
    och_q   <= och_d;
    olast_q <= olast_d;
  end

  assign busy_o        = busy;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = och_q;
  assign m_axis_tlast  = olast_q;

endmodule
